// File: sv/mprq_pkg.sv
// Shared types and codes for the multilevel priority run queue.
// No dependencies; imported by the cell, row and top-level modules.
package mprq_pkg;

    // Command codes carried in the mode field
    localparam logic [1:0] MODE_ENQ  = 2'd0;
    localparam logic [1:0] MODE_DEQ  = 2'd1;
    localparam logic [1:0] MODE_REM  = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_BADPRIO  = 3'd2,
        ST_FULL     = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_NOTFOUND = 3'd5
    } t_status;

    localparam int ID_W   = 16;
    localparam int PRIO_W = 4;

    // Command transfer
    typedef struct packed {
        logic [1:0]        mode;
        logic [ID_W-1:0]   task_id;
        logic [PRIO_W-1:0] priority_req;
    } t_req;

    // Result transfer
    typedef struct packed {
        logic [ID_W-1:0]   granted_id;
        logic [PRIO_W-1:0] granted_level;
        logic [2:0]        status;
    } t_rsp;

    // Per-level control broadcast to every cell of one row
    typedef struct packed {
        logic load;       // latch match flag against the key
        logic force_all;  // with load: mark every cell (head removal)
        logic walk;       // spread the flag one cell toward the tail
        logic shift;      // flagged cells take their tail neighbor
        logic append;     // first empty cell takes the key
    } t_cell_ctl;

endpackage

// File: sv/mprq_cell.sv
// One queue slot: a task id, its valid bit and a removal flag.
// Depends on mprq_pkg; used by mprq_row.
module mprq_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mprq_pkg::t_cell_ctl  i_ctl,
    input  logic [15:0]          i_key,
    input  logic                 i_prev_flag,
    input  logic                 i_prev_valid,
    input  logic [15:0]          i_next_id,
    input  logic                 i_next_valid,
    output logic [15:0]          o_id,
    output logic                 o_valid,
    output logic                 o_flag
);
    import mprq_pkg::*;

    logic [15:0] r_id;
    logic        r_valid;
    logic        r_flag;
    logic        w_take_next;
    logic        w_take_key;

    assign w_take_next = i_ctl.shift && r_flag;
    assign w_take_key  = i_ctl.append && !r_valid && i_prev_valid;

    // Occupancy: move up on removal, fill on append
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take_next) begin
            r_valid <= i_next_valid;
        end else if (w_take_key) begin
            r_valid <= 1'b1;
        end
    end

    // Payload and flag
    always_ff @(posedge i_clk) begin
        if (w_take_next) begin
            r_id <= i_next_id;
        end else if (w_take_key) begin
            r_id <= i_key;
        end
        if (i_ctl.load) begin
            r_flag <= i_ctl.force_all || (r_valid && (r_id == i_key));
        end else if (i_ctl.walk) begin
            r_flag <= r_flag || i_prev_flag;
        end
    end

    assign o_id    = r_id;
    assign o_valid = r_valid;
    assign o_flag  = r_flag;

endmodule

// File: sv/mprq_row.sv
// One priority level: a chain of mprq_cell slots, head at cell 0.
// Depends on mprq_pkg and mprq_cell; used by the top level.
module mprq_row #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mprq_pkg::t_cell_ctl  i_ctl,
    input  logic [15:0]          i_key,
    output logic [15:0]          o_head,
    output logic                 o_nonempty,
    output logic                 o_full,
    output logic                 o_hit
);
    import mprq_pkg::*;

    logic [15:0]            w_id [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_valid;
    logic [QUEUE_DEPTH-1:0] w_flag;

    // Chain the cells: flags and fill walk tailward, data moves headward
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic        w_prev_flag;
        logic        w_prev_valid;
        logic [15:0] w_next_id;
        logic        w_next_valid;

        if (i == 0) begin : g_head
            assign w_prev_flag  = 1'b0;
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_flag  = w_flag[i-1];
            assign w_prev_valid = w_valid[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign w_next_id    = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_inner
            assign w_next_id    = w_id[i+1];
            assign w_next_valid = w_valid[i+1];
        end

        mprq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_key        (i_key),
            .i_prev_flag  (w_prev_flag),
            .i_prev_valid (w_prev_valid),
            .i_next_id    (w_next_id),
            .i_next_valid (w_next_valid),
            .o_id         (w_id[i]),
            .o_valid      (w_valid[i]),
            .o_flag       (w_flag[i])
        );
    end

    assign o_head     = w_id[0];
    assign o_nonempty = w_valid[0];
    assign o_full     = w_valid[QUEUE_DEPTH-1];
    // After the walk the tail flag is the OR of all matches
    assign o_hit      = w_flag[QUEUE_DEPTH-1];

    // Occupied slots always form a contiguous run from the head
    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[QUEUE_DEPTH-1:1] & ~w_valid[QUEUE_DEPTH-2:0]) == '0)
        else $error("row occupancy has a gap");

    // Append and shift never act together
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.append && i_ctl.shift))
        else $error("row append and shift together");

endmodule

// File: sv/multilevel_priority_run_queue.sv
// Multilevel priority run queue: one id FIFO per level, rows of chained cells.
// Enqueue/remove: the result strobe follows the transfer after a match, a flag walk along
// the row and an apply step. Dequeue with work goes straight from transfer to apply.
// Bad priority, all-empty dequeue and unused mode are answered from the transfer; busy stays low.
// A new command is taken only while busy is low; results cannot be stalled.
// Synchronous active-low reset empties every level; no clearing pass.
module multilevel_priority_run_queue #(
    parameter int LEVELS      = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  mprq_pkg::t_req i_req,
    output logic           o_valid,
    output mprq_pkg::t_rsp o_rsp
);
    import mprq_pkg::*;

    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [CW-1:0] WALK_LAST = CW'(QUEUE_DEPTH - 2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_APPLY
    } t_state;

    t_state          r_state;
    logic [1:0]      r_op;
    logic [15:0]     r_key;
    logic [LW-1:0]   r_lvl;
    logic [CW-1:0]   r_cnt;
    logic            r_valid;
    t_rsp            r_rsp;
    logic            n_valid;
    t_rsp            n_rsp;

    t_cell_ctl       w_ctl       [LEVELS];
    logic [15:0]     w_head      [LEVELS];
    logic [LEVELS-1:0] w_nonempty;
    logic [LEVELS-1:0] w_full;
    logic [LEVELS-1:0] w_hit;

    logic            w_acc;
    logic            w_prio_ok;
    logic            w_any;
    logic [LW-1:0]   w_deq_lvl;
    logic [LW-1:0]   n_lvl;
    logic            w_load;
    logic [15:0]     w_key;
    logic            w_do_shift;
    logic            w_do_append;
    t_rsp            w_apply_rsp;

    assign busy  = (r_state != S_IDLE);
    assign w_acc = start && !busy;
    assign w_prio_ok = (32'(i_req.priority_req) < LEVELS);
    assign w_any = |w_nonempty;
    assign w_key = (r_state == S_IDLE) ? i_req.task_id : r_key;

    // Pick the lowest-numbered nonempty level
    always_comb begin
        w_deq_lvl = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (w_nonempty[l]) begin
                w_deq_lvl = LW'(l);
            end
        end
    end

    assign n_lvl  = (i_req.mode == MODE_DEQ) ? w_deq_lvl : i_req.priority_req[LW-1:0];
    assign w_load = w_acc && ((((i_req.mode == MODE_ENQ) || (i_req.mode == MODE_REM))
                              && w_prio_ok) || ((i_req.mode == MODE_DEQ) && w_any));

    // Decide the final action for the selected level
    always_comb begin
        w_do_shift  = 1'b0;
        w_do_append = 1'b0;
        w_apply_rsp = '0;
        unique case (r_op)
            MODE_ENQ: begin
                if (w_hit[r_lvl]) begin
                    w_apply_rsp.status = ST_DUP;
                end else if (w_full[r_lvl]) begin
                    w_apply_rsp.status = ST_FULL;
                end else begin
                    w_do_append        = 1'b1;
                    w_apply_rsp.status = ST_OK;
                end
            end
            MODE_REM: begin
                w_do_shift         = w_hit[r_lvl];
                w_apply_rsp.status = w_hit[r_lvl] ? ST_OK : ST_NOTFOUND;
            end
            MODE_DEQ: begin
                w_do_shift                = 1'b1;
                w_apply_rsp.granted_id    = w_head[r_lvl];
                w_apply_rsp.granted_level = PRIO_W'(r_lvl);
                w_apply_rsp.status        = ST_OK;
            end
            default: begin
                w_apply_rsp.status = ST_OK;
            end
        endcase
    end

    // Select the next result: immediate answers at transfer, full answers at apply
    always_comb begin
        n_valid = 1'b0;
        n_rsp   = r_rsp;
        if (r_state == S_APPLY) begin
            n_valid = 1'b1;
            n_rsp   = w_apply_rsp;
        end else if ((r_state == S_IDLE) && w_acc) begin
            unique case (i_req.mode)
                MODE_ENQ, MODE_REM: begin
                    if (!w_prio_ok) begin
                        n_valid      = 1'b1;
                        n_rsp        = '0;
                        n_rsp.status = ST_BADPRIO;
                    end
                end
                MODE_DEQ: begin
                    if (!w_any) begin
                        n_valid      = 1'b1;
                        n_rsp        = '0;
                        n_rsp.status = ST_EMPTY;
                    end
                end
                default: begin
                    n_valid      = 1'b1;
                    n_rsp        = '0;
                    n_rsp.status = ST_OK;
                end
            endcase
        end
    end

    // Level rows with their control
    for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
        always_comb begin
            w_ctl[l].load      = w_load && (n_lvl == LW'(l));
            w_ctl[l].force_all = (i_req.mode == MODE_DEQ);
            w_ctl[l].walk      = (r_state == S_WALK) && (r_lvl == LW'(l));
            w_ctl[l].shift     = (r_state == S_APPLY) && w_do_shift && (r_lvl == LW'(l));
            w_ctl[l].append    = (r_state == S_APPLY) && w_do_append && (r_lvl == LW'(l));
        end

        mprq_row #(
            .QUEUE_DEPTH (QUEUE_DEPTH)
        ) u_row (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl[l]),
            .i_key      (w_key),
            .o_head     (w_head[l]),
            .o_nonempty (w_nonempty[l]),
            .o_full     (w_full[l]),
            .o_hit      (w_hit[l])
        );
    end

    // Sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_rsp   <= '0;
            r_op    <= MODE_NONE;
            r_key   <= '0;
            r_lvl   <= '0;
            r_cnt   <= '0;
        end else begin
            r_valid <= n_valid;
            r_rsp   <= n_rsp;
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_op  <= i_req.mode;
                        r_key <= i_req.task_id;
                        r_lvl <= n_lvl;
                        r_cnt <= '0;
                        if (w_load) begin
                            r_state <= (i_req.mode == MODE_DEQ) ? S_APPLY : S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == WALK_LAST) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // A result is only presented once the block is free again
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // The apply step always produces a result next cycle
    a_apply_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |=> o_valid)
        else $error("apply without result");

    // A non-grant result carries no id
    a_nogrant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.status != ST_OK)) |-> (o_rsp.granted_id == '0))
        else $error("id on failed command");

    // A valid enqueue or remove enters the walk
    a_enq_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_prio_ok && ((i_req.mode == MODE_ENQ) || (i_req.mode == MODE_REM)))
        |=> (r_state == S_WALK))
        else $error("enqueue or remove skipped walk");

endmodule
